### hw/rtl/cts_pkg.sv
package cts_pkg;

    localparam logic [3:0] OP_REGISTER   = 4'd0;
    localparam logic [3:0] OP_START      = 4'd1;
    localparam logic [3:0] OP_SELECT     = 4'd2;
    localparam logic [3:0] OP_COMPLETE   = 4'd3;
    localparam logic [3:0] OP_ENABLE     = 4'd4;
    localparam logic [3:0] OP_DISABLE    = 4'd5;
    localparam logic [3:0] OP_SUSPEND    = 4'd6;
    localparam logic [3:0] OP_RESUME     = 4'd7;
    localparam logic [3:0] OP_SET_HEALTH = 4'd8;

    localparam logic [2:0] RS_CREATED   = 3'd0;
    localparam logic [2:0] RS_READY     = 3'd1;
    localparam logic [2:0] RS_RUNNING   = 3'd2;
    localparam logic [2:0] RS_SUSPENDED = 3'd3;
    localparam logic [2:0] RS_ERROR     = 3'd4;

    localparam logic [1:0] HL_UNKNOWN  = 2'd0;
    localparam logic [1:0] HL_OK       = 2'd1;
    localparam logic [1:0] HL_WARNING  = 2'd2;
    localparam logic [1:0] HL_CRITICAL = 2'd3;

    localparam logic [2:0] RC_OK        = 3'd0;
    localparam logic [2:0] RC_NO_ACTION = 3'd1;
    localparam logic [2:0] RC_YIELD     = 3'd2;

    localparam logic CFG_WATCHDOG_ENABLE = 1'b0;
    localparam logic CFG_TIMING_ENABLE   = 1'b1;

    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  task_index;
        logic [2:0]  prio_level;
        logic [31:0] period_ticks;
        logic [31:0] declared_wcet_us;
        logic [31:0] now_tick;
        logic [31:0] exec_time_us;
        logic [2:0]  result_code;
        logic [1:0]  new_health;
    } t_in;

    typedef struct packed {
        logic       ok;
        logic [3:0] chosen_index;
        logic       feed_watchdog;
    } t_out;

    typedef struct packed {
        logic latch;
        logic simple;
        logic sel_init;
        logic sel_issue;
        logic sel_take;
        logic cmp_upd;
        logic feed_step;
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       ptr_end;
        logic       found;
    } t_stat;

endpackage

### hw/rtl/cts_ram.sv
module cts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/cts_ctrl.sv
module cts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cts_pkg::t_stat i_stat,
    output cts_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DISP    = 7'b0000010,
        S_SEL     = 7'b0000100,
        S_SEL_FIN = 7'b0001000,
        S_CMP     = 7'b0010000,
        S_FEED    = 7'b0100000,
        S_SPARE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    cts_pkg::OP_SELECT: begin
                        o_cmd.sel_init = 1'b1;
                        n_state        = S_SEL;
                    end
                    cts_pkg::OP_COMPLETE: begin
                        n_state = S_CMP;
                    end
                    default: begin
                        o_cmd.simple = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_SEL: begin
                o_cmd.sel_issue = 1'b1;
                if (i_stat.ptr_end) begin
                    n_state = S_SEL_FIN;
                end
            end
            S_SEL_FIN: begin
                o_cmd.sel_take = 1'b1;
                n_state = i_stat.found ? S_IDLE : S_FEED;
            end
            S_CMP: begin
                o_cmd.cmp_upd = 1'b1;
                n_state       = S_FEED;
            end
            S_FEED: begin
                o_cmd.feed_step = 1'b1;
                if (i_stat.ptr_end) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

### hw/rtl/cts_dp.sv
module cts_dp #(
    parameter int MAX_TASKS       = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_data,
    input  cts_pkg::t_in  i_item,
    input  cts_pkg::t_cmd i_cmd,
    output cts_pkg::t_stat o_stat,
    output logic          o_done,
    output cts_pkg::t_out o_result
);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic          r_wd_en, r_tim_en;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    cts_pkg::t_in  r_item;
    logic [2:0]    r_prio   [MAX_TASKS];
    logic [2:0]    r_rs     [MAX_TASKS];
    logic [1:0]    r_health [MAX_TASKS];
    logic          r_en     [MAX_TASKS];
    logic          r_eval;
    logic [IW-1:0] r_dptr;
    logic [3:0]    r_best;
    logic [IW-1:0] r_pick;
    logic          r_found;
    logic          r_bad;
    logic          r_ok;
    logic          r_done;
    cts_pkg::t_out r_res;
    logic          n_done;
    cts_pkg::t_out n_res;

    logic [31:0]   period_rd, last_rd, wcet_rd, maxexec_rd;
    logic [IW-1:0] cnt_ix, idx_ix, ptr_ix;
    logic          ptr_end, valid, reg_do, due, cand;
    logic          cmp_run, newmax;
    logic [2:0]    cmp_rs;
    logic [1:0]    cmp_hl;
    logic          lr_we, mx_we;

    assign cnt_ix  = IW'(r_count);
    assign idx_ix  = IW'(r_item.task_index);
    assign ptr_ix  = IW'(r_ptr);
    assign ptr_end = (r_ptr >= r_count);
    assign valid   = (32'(r_item.task_index) < 32'(r_count));
    assign reg_do  = i_cmd.simple && (r_item.op == cts_pkg::OP_REGISTER)
                     && (32'(r_item.prio_level) < PRIORITY_LEVELS)
                     && (32'(r_count) < MAX_TASKS);

    assign due  = (period_rd == 32'd0) || ((r_item.now_tick - last_rd) >= period_rd);
    assign cand = r_eval && r_en[r_dptr] && (r_rs[r_dptr] == cts_pkg::RS_READY) && due
                  && ({1'b0, r_prio[r_dptr]} < r_best);

    assign cmp_run = i_cmd.cmp_upd && valid && (r_rs[idx_ix] == cts_pkg::RS_RUNNING);
    assign newmax  = r_tim_en && (r_item.exec_time_us > maxexec_rd);

    always_comb begin
        cmp_hl = r_health[idx_ix];
        if (newmax && (r_item.exec_time_us > wcet_rd)) begin
            cmp_hl = cts_pkg::HL_WARNING;
        end
        case (r_item.result_code)
            cts_pkg::RC_OK, cts_pkg::RC_NO_ACTION: begin
                cmp_rs = cts_pkg::RS_READY;
                if (cmp_hl == cts_pkg::HL_UNKNOWN) begin
                    cmp_hl = cts_pkg::HL_OK;
                end
            end
            cts_pkg::RC_YIELD: begin
                cmp_rs = cts_pkg::RS_READY;
            end
            default: begin
                cmp_rs = cts_pkg::RS_ERROR;
                cmp_hl = cts_pkg::HL_CRITICAL;
            end
        endcase
    end

    assign lr_we = reg_do || cmp_run;
    assign mx_we = reg_do || (cmp_run && newmax);

    cts_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_period (
        .i_clk(i_clk), .i_we(reg_do), .i_waddr(cnt_ix), .i_wdata(r_item.period_ticks),
        .i_raddr(ptr_ix), .o_rdata(period_rd)
    );
    cts_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_last (
        .i_clk(i_clk), .i_we(lr_we), .i_waddr(reg_do ? cnt_ix : idx_ix),
        .i_wdata(reg_do ? 32'd0 : r_item.now_tick),
        .i_raddr(ptr_ix), .o_rdata(last_rd)
    );
    cts_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_wcet (
        .i_clk(i_clk), .i_we(reg_do), .i_waddr(cnt_ix),
        .i_wdata(r_item.declared_wcet_us),
        .i_raddr(idx_ix), .o_rdata(wcet_rd)
    );
    cts_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_maxexec (
        .i_clk(i_clk), .i_we(mx_we), .i_waddr(reg_do ? cnt_ix : idx_ix),
        .i_wdata(reg_do ? 32'd0 : r_item.exec_time_us),
        .i_raddr(idx_ix), .o_rdata(maxexec_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd_en  <= 1'b0;
            r_tim_en <= 1'b0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_eval   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == cts_pkg::CFG_WATCHDOG_ENABLE) begin
                    r_wd_en <= i_cfg_data;
                end else begin
                    r_tim_en <= i_cfg_data;
                end
            end
            if (reg_do) begin
                r_count <= r_count + 1'b1;
            end
            r_done <= n_done;
            r_eval <= i_cmd.sel_issue && !ptr_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        r_res  <= n_res;
        r_dptr <= ptr_ix;

        if (i_cmd.sel_init || i_cmd.cmp_upd || i_cmd.sel_take) begin
            r_ptr <= '0;
            r_bad <= 1'b0;
        end else if ((i_cmd.sel_issue || i_cmd.feed_step) && !ptr_end) begin
            r_ptr <= r_ptr + 1'b1;
            if (i_cmd.feed_step && r_en[ptr_ix]
                && (r_health[ptr_ix] == cts_pkg::HL_UNKNOWN
                    || r_health[ptr_ix] == cts_pkg::HL_CRITICAL)) begin
                r_bad <= 1'b1;
            end
        end

        if (i_cmd.sel_init) begin
            r_best  <= 4'(PRIORITY_LEVELS);
            r_pick  <= '0;
            r_found <= 1'b0;
        end else if (cand) begin
            r_best  <= {1'b0, r_prio[r_dptr]};
            r_pick  <= r_dptr;
            r_found <= 1'b1;
        end

        if (i_cmd.sel_take) begin
            r_ok <= 1'b0;
        end else if (i_cmd.cmp_upd) begin
            r_ok <= cmp_run;
        end

        for (int i = 0; i < MAX_TASKS; i++) begin
            if (i_cmd.simple && (r_item.op == cts_pkg::OP_START)
                && (32'(i) < 32'(r_count))) begin
                r_rs[i] <= cts_pkg::RS_READY;
                r_en[i] <= 1'b1;
            end
        end
        if (reg_do) begin
            r_prio[cnt_ix]   <= r_item.prio_level;
            r_rs[cnt_ix]     <= cts_pkg::RS_CREATED;
            r_health[cnt_ix] <= cts_pkg::HL_UNKNOWN;
            r_en[cnt_ix]     <= 1'b0;
        end
        if (i_cmd.simple && valid) begin
            case (r_item.op)
                cts_pkg::OP_ENABLE:     r_en[idx_ix]     <= 1'b1;
                cts_pkg::OP_DISABLE:    r_en[idx_ix]     <= 1'b0;
                cts_pkg::OP_SUSPEND:    r_rs[idx_ix]     <= cts_pkg::RS_SUSPENDED;
                cts_pkg::OP_RESUME:     r_rs[idx_ix]     <= cts_pkg::RS_READY;
                cts_pkg::OP_SET_HEALTH: r_health[idx_ix] <= r_item.new_health;
                default: ;
            endcase
        end
        if (i_cmd.sel_take && r_found) begin
            r_rs[r_pick] <= cts_pkg::RS_RUNNING;
        end
        if (cmp_run) begin
            r_rs[idx_ix]     <= cmp_rs;
            r_health[idx_ix] <= cmp_hl;
        end
    end

    always_comb begin
        n_res  = '0;
        n_done = 1'b0;
        if (i_cmd.simple) begin
            n_done = 1'b1;
            case (r_item.op)
                cts_pkg::OP_REGISTER: begin
                    n_res.ok = reg_do;
                    if (reg_do) begin
                        n_res.chosen_index = 4'(r_count);
                    end
                end
                cts_pkg::OP_START: n_res.ok = 1'b1;
                cts_pkg::OP_ENABLE, cts_pkg::OP_DISABLE, cts_pkg::OP_SUSPEND,
                cts_pkg::OP_RESUME, cts_pkg::OP_SET_HEALTH: n_res.ok = valid;
                default: ;
            endcase
        end else if (i_cmd.sel_take && r_found) begin
            n_done             = 1'b1;
            n_res.ok           = 1'b1;
            n_res.chosen_index = 4'(r_pick);
        end else if (i_cmd.feed_step && ptr_end) begin
            n_done              = 1'b1;
            n_res.ok            = r_ok;
            n_res.feed_watchdog = r_wd_en && !r_bad;
        end
    end

    assign o_stat.op      = r_item.op;
    assign o_stat.ptr_end = ptr_end;
    assign o_stat.found   = r_found;
    assign o_done         = r_done;
    assign o_result       = r_res;
endmodule

### hw/rtl/cooperative_task_scheduler.sv
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------
// command   | i_start, o_busy           | i_item (cts_pkg::t_in)
// result    | o_done (one-cycle strobe) | o_result (cts_pkg::t_out)
// config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// a transaction is taken when i_start is high and o_busy low; one result per transaction
// simple ops: dispatched and answered directly; select: a scan of all registered slots,
// then a health scan when nothing is due; complete: a task update, then a health scan
// the slot scans read one table entry per cycle through the ram read port
// synchronous active-low reset clears task count and config; no clearing pass needed
// results cannot be stalled by the receiver
module cooperative_task_scheduler #(
    parameter int MAX_TASKS       = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cts_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_done,
    output cts_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_data
);
    cts_pkg::t_cmd  cmd;
    cts_pkg::t_stat stat;
    logic           busy;

    cts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    cts_dp #(.MAX_TASKS(MAX_TASKS), .PRIORITY_LEVELS(PRIORITY_LEVELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_item(i_item), .i_cmd(cmd), .o_stat(stat),
        .o_done(o_done), .o_result(o_result)
    );

    assign o_busy = busy;
endmodule

### test/tb_cooperative_task_scheduler.sv
`timescale 1ns / 100ps

module tb_cooperative_task_scheduler;

    localparam int NUM_SLOTS  = 16;
    localparam int NUM_PRIO   = 4;
    localparam int STALL_MAX  = 500;
    localparam int SETTLE_CYC = 60;

    typedef struct {
        logic [4:0]  count;
        logic [2:0]  prio     [NUM_SLOTS];
        logic [31:0] period   [NUM_SLOTS];
        logic [31:0] wcet     [NUM_SLOTS];
        logic [31:0] last_run [NUM_SLOTS];
        logic [2:0]  run_st   [NUM_SLOTS];
        logic [1:0]  health   [NUM_SLOTS];
        logic        enabled  [NUM_SLOTS];
        logic [31:0] max_exec [NUM_SLOTS];
    } t_sched;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    cts_pkg::t_in   i_item;
    logic           o_busy;
    logic           o_done;
    cts_pkg::t_out  o_result;
    logic           i_cfg_we;
    logic           i_cfg_idx;
    logic           i_cfg_data;

    t_sched         table_model;
    t_sched         plan_model;
    bit             wdog_en;
    bit             timing_en;
    cts_pkg::t_in   cmd_q[$];
    cts_pkg::t_out  result_q[$];
    int             idle_left;
    bit             idle_on;
    int             stall_cnt;
    int             err_cnt;
    logic [31:0]    now_cur;

    cooperative_task_scheduler DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_item     (i_item),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void clear_table(inout t_sched s);
        s.count = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            s.prio[i] = '0; s.period[i] = '0; s.wcet[i] = '0; s.last_run[i] = '0;
            s.run_st[i] = cts_pkg::RS_CREATED; s.health[i] = cts_pkg::HL_UNKNOWN;
            s.enabled[i] = 1'b0; s.max_exec[i] = '0;
        end
    endfunction

    function automatic logic feed_ok(t_sched s, bit wd);
        if (!wd) return 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (i < s.count && s.enabled[i] &&
                (s.health[i] == cts_pkg::HL_UNKNOWN || s.health[i] == cts_pkg::HL_CRITICAL))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic cts_pkg::t_out sched_step(inout t_sched s, input cts_pkg::t_in it,
                                                 input bit wd, input bit te);
        cts_pkg::t_out r;
        bit   hit;
        int   ix;
        int   best;
        int   pick;
        r = '0;
        ix = it.task_index;
        hit = ix < s.count;
        case (it.op)
            cts_pkg::OP_REGISTER: begin
                if (it.prio_level < NUM_PRIO && s.count < NUM_SLOTS) begin
                    ix = s.count;
                    s.prio[ix] = it.prio_level; s.period[ix] = it.period_ticks;
                    s.wcet[ix] = it.declared_wcet_us; s.last_run[ix] = '0;
                    s.run_st[ix] = cts_pkg::RS_CREATED; s.health[ix] = cts_pkg::HL_UNKNOWN;
                    s.enabled[ix] = 1'b0; s.max_exec[ix] = '0;
                    s.count = s.count + 5'd1;
                    r.ok = 1'b1; r.chosen_index = ix[3:0];
                end
            end
            cts_pkg::OP_START: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (i < s.count) begin
                        s.run_st[i] = cts_pkg::RS_READY; s.enabled[i] = 1'b1;
                    end
                r.ok = 1'b1;
            end
            cts_pkg::OP_SELECT: begin
                best = NUM_PRIO; pick = -1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (i < s.count && s.enabled[i] && s.run_st[i] == cts_pkg::RS_READY &&
                        (s.period[i] == 0 ||
                         32'(it.now_tick - s.last_run[i]) >= s.period[i]) &&
                        s.prio[i] < best) begin
                        best = s.prio[i]; pick = i;
                    end
                end
                if (pick >= 0) begin
                    s.run_st[pick] = cts_pkg::RS_RUNNING;
                    r.ok = 1'b1; r.chosen_index = pick[3:0];
                end else
                    r.feed_watchdog = feed_ok(s, wd);
            end
            cts_pkg::OP_COMPLETE: begin
                if (hit && s.run_st[ix] == cts_pkg::RS_RUNNING) begin
                    if (te && it.exec_time_us > s.max_exec[ix]) begin
                        s.max_exec[ix] = it.exec_time_us;
                        if (it.exec_time_us > s.wcet[ix]) s.health[ix] = cts_pkg::HL_WARNING;
                    end
                    if (it.result_code == cts_pkg::RC_OK ||
                        it.result_code == cts_pkg::RC_NO_ACTION) begin
                        s.run_st[ix] = cts_pkg::RS_READY;
                        if (s.health[ix] == cts_pkg::HL_UNKNOWN) s.health[ix] = cts_pkg::HL_OK;
                    end else if (it.result_code == cts_pkg::RC_YIELD) begin
                        s.run_st[ix] = cts_pkg::RS_READY;
                    end else begin
                        s.run_st[ix] = cts_pkg::RS_ERROR; s.health[ix] = cts_pkg::HL_CRITICAL;
                    end
                    s.last_run[ix] = it.now_tick;
                    r.ok = 1'b1;
                end
                r.feed_watchdog = feed_ok(s, wd);
            end
            cts_pkg::OP_ENABLE:
                if (hit) begin s.enabled[ix] = 1'b1; r.ok = 1'b1; end
            cts_pkg::OP_DISABLE:
                if (hit) begin s.enabled[ix] = 1'b0; r.ok = 1'b1; end
            cts_pkg::OP_SUSPEND:
                if (hit) begin s.run_st[ix] = cts_pkg::RS_SUSPENDED; r.ok = 1'b1; end
            cts_pkg::OP_RESUME:
                if (hit) begin s.run_st[ix] = cts_pkg::RS_READY; r.ok = 1'b1; end
            cts_pkg::OP_SET_HEALTH:
                if (hit) begin s.health[ix] = it.new_health; r.ok = 1'b1; end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cts_pkg::t_in rand_cmd(logic [3:0] op);
        cts_pkg::t_in it;
        it.op               = op;
        it.task_index       = 4'($urandom_range(0, 15));
        it.prio_level       = 3'($urandom_range(0, 7));
        it.period_ticks     = $urandom;
        it.declared_wcet_us = $urandom;
        it.now_tick         = $urandom;
        it.exec_time_us     = $urandom;
        it.result_code      = 3'($urandom_range(0, 7));
        it.new_health       = 2'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic cts_pkg::t_out plan(cts_pkg::t_in it);
        cmd_q.push_back(it);
        return sched_step(plan_model, it, wdog_en, timing_en);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                result_q.push_back(sched_step(table_model, i_item, wdog_en, timing_en));
                void'(cmd_q.pop_front());
            end
            if (i_start && o_busy) begin
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                i_start   <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                idle_left <= $urandom_range(0, 5);
                i_start   <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                i_start <= 1'b1;
                i_item  <= cmd_q[0];
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cts_pkg::t_out want;
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                $error("result with nothing expected: %p", o_result);
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                if (o_result.ok !== want.ok) begin
                    $error("ok: expected %0d actual %0d", want.ok, o_result.ok);
                    err_cnt++;
                end
                if (o_result.chosen_index !== want.chosen_index) begin
                    $error("chosen_index: expected %0d actual %0d",
                           want.chosen_index, o_result.chosen_index);
                    err_cnt++;
                end
                if (o_result.feed_watchdog !== want.feed_watchdog) begin
                    $error("feed_watchdog: expected %0d actual %0d",
                           want.feed_watchdog, o_result.feed_watchdog);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done || cmd_q.size() == 0 && result_q.size() == 0)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_MAX) begin
            $display("tb_cooperative_task_scheduler: errors");
            $finish;
        end else
            stall_cnt <= stall_cnt + 1;
    end

    task automatic cfg_write(logic idx, logic val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == cts_pkg::CFG_WATCHDOG_ENABLE) wdog_en = val; else timing_en = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || result_q.size() != 0 || i_start)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic directed_part();
        cts_pkg::t_in  it;
        cts_pkg::t_out r;
        r = plan(rand_cmd(cts_pkg::OP_START));
        it = rand_cmd(cts_pkg::OP_SELECT); it.now_tick = '0; r = plan(it);
        it = rand_cmd(cts_pkg::OP_REGISTER); it.prio_level = 3'd0; it.period_ticks = '0;
        it.declared_wcet_us = 32'd10; r = plan(it);
        it = rand_cmd(cts_pkg::OP_REGISTER); it.prio_level = 3'd3; it.period_ticks = '1;
        it.declared_wcet_us = '0; r = plan(it);
        it = rand_cmd(cts_pkg::OP_REGISTER); it.prio_level = 3'd4; r = plan(it);
        it = rand_cmd(cts_pkg::OP_REGISTER); it.prio_level = 3'd7; r = plan(it);
        it = rand_cmd(cts_pkg::OP_REGISTER); it.prio_level = 3'd0; it.period_ticks = 32'd5;
        it.declared_wcet_us = '1; r = plan(it);
        r = plan(rand_cmd(cts_pkg::OP_START));
        it = rand_cmd(cts_pkg::OP_SELECT); it.now_tick = 32'hFFFF_FFFE; r = plan(it);
        it = rand_cmd(cts_pkg::OP_COMPLETE); it.task_index = r.chosen_index;
        it.exec_time_us = 32'd100; it.result_code = cts_pkg::RC_OK; r = plan(it);
        it = rand_cmd(cts_pkg::OP_SELECT); it.now_tick = 32'd2; r = plan(it);
        it = rand_cmd(cts_pkg::OP_COMPLETE); it.task_index = r.chosen_index;
        it.exec_time_us = '1; it.result_code = 3'd7; r = plan(it);
        it = rand_cmd(cts_pkg::OP_COMPLETE); it.task_index = 4'd1; r = plan(it);
        it = rand_cmd(cts_pkg::OP_COMPLETE); it.task_index = 4'd15; r = plan(it);
        for (int op = cts_pkg::OP_ENABLE; op <= cts_pkg::OP_SET_HEALTH; op++) begin
            it = rand_cmd(4'(op)); it.task_index = 4'd1; r = plan(it);
            it = rand_cmd(4'(op)); it.task_index = 4'd15; r = plan(it);
        end
        for (int op = cts_pkg::OP_SET_HEALTH + 1; op <= 15; op++)
            r = plan(rand_cmd(4'(op)));
    endtask

    task automatic random_part(int n);
        cts_pkg::t_in  it;
        cts_pkg::t_out r;
        int   k;
        k = 0;
        while (k < n) begin
            now_cur = now_cur + ($urandom_range(0, 19) == 0 ? $urandom : $urandom_range(0, 8));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
                    it = rand_cmd(cts_pkg::OP_SELECT); it.now_tick = now_cur;
                    r = plan(it); k++;
                    if (r.ok && $urandom_range(0, 7) != 0) begin
                        it = rand_cmd(cts_pkg::OP_COMPLETE); it.task_index = r.chosen_index;
                        it.now_tick = now_cur;
                        if ($urandom_range(0, 1)) it.result_code = 3'($urandom_range(0, 2));
                        if ($urandom_range(0, 1)) it.exec_time_us = $urandom_range(0, 300);
                        r = plan(it); k++;
                    end
                end
                10, 11: begin
                    it = rand_cmd(cts_pkg::OP_REGISTER);
                    if ($urandom_range(0, 3) != 0) it.period_ticks = $urandom_range(0, 20);
                    if ($urandom_range(0, 1)) it.declared_wcet_us = $urandom_range(0, 300);
                    r = plan(it); k++;
                end
                12, 13: begin
                    it = rand_cmd(cts_pkg::OP_SET_HEALTH);
                    if ($urandom_range(0, 2) != 0) it.new_health = cts_pkg::HL_OK;
                    it.task_index = 4'($urandom_range(0, plan_model.count));
                    r = plan(it); k++;
                end
                14: begin r = plan(rand_cmd(cts_pkg::OP_START)); k++; end
                default: begin
                    it = rand_cmd(4'($urandom_range(cts_pkg::OP_COMPLETE, 15)));
                    if ($urandom_range(0, 1)) it.task_index = 4'($urandom_range(0, plan_model.count));
                    r = plan(it); k++;
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = 1'b0;
        i_cfg_data = 1'b0;
        idle_left  = 0;
        idle_on    = 1'b1;
        err_cnt    = 0;
        wdog_en    = 1'b0;
        timing_en  = 1'b0;
        now_cur    = '0;
        clear_table(table_model);
        clear_table(plan_model);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_write(cts_pkg::CFG_WATCHDOG_ENABLE, 1'b1);
        cfg_write(cts_pkg::CFG_TIMING_ENABLE, 1'b1);
        directed_part();
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(cts_pkg::CFG_WATCHDOG_ENABLE, ph == 1 || ph == 2 || ph >= 4);
            cfg_write(cts_pkg::CFG_TIMING_ENABLE, ph == 1 || ph == 3 || ph >= 4);
            idle_on = ph != 5;
            random_part(300);
            drain();
        end
        if (err_cnt == 0)
            $display("tb_cooperative_task_scheduler: clean");
        else
            $display("tb_cooperative_task_scheduler: errors");
        $finish;
    end

endmodule
